/* hw/rtl/vsd_pkg.sv */
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and fixed-point constants of the vehicle stuck detector.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int CFG_W   = 15;
    localparam int SCORE_W = 15;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [SCORE_W-1:0] SCORE_ONE = 15'd16384;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 15'd32767;
    localparam logic [SCORE_W-1:0] TRAJ_STEP = 15'd2458;
    localparam logic [SCORE_W-1:0] VEL_STEP  = 15'd1638;

    localparam logic [13:0] KEEP_COEF = 14'd13107;
    localparam logic [11:0] NEW_COEF  = 12'd3277;
    localparam logic [13:0] HALF_Q14  = 14'd8192;

    localparam logic [CFG_W-1:0] MIN_MOVE_RST   = 15'd102;
    localparam logic [CFG_W-1:0] MIN_TURN_RST   = 15'd1024;
    localparam logic [CFG_W-1:0] STILL_RATE_RST = 15'd328;

    typedef enum logic [1:0] {
        CFG_MIN_MOVE   = 2'd0,
        CFG_MIN_TURN   = 2'd1,
        CFG_STILL_RATE = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_POINT    = 1'b0,
        OP_VELOCITY = 1'b1
    } t_op;

    typedef struct packed {
        logic [CFG_W-1:0] min_move;
        logic [CFG_W-1:0] min_turn;
        logic [CFG_W-1:0] still_rate;
    } t_cfg;

    typedef struct packed {
        logic from_velocity;
        logic evidence;
    } t_decision;

endpackage

/* hw/rtl/vsd_front.sv */
// ----------------------------------------------------------------------------
// vsd_front
// Accepts points and velocity samples, tracks the reference, the distance and
// heading maxima and the speed filters, and classifies each deciding item.
// ----------------------------------------------------------------------------
module vsd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vsd_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_operation,
    input  logic                  i_first_point,
    input  logic                  i_last_point,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic signed [15:0]    i_heading,
    input  logic signed [15:0]    i_speed,
    input  logic signed [15:0]    i_turn_rate,
    input  logic                  i_target_reached,
    input  logic                  i_planner_started,
    output logic                  o_push,
    output vsd_pkg::t_decision    o_dec,
    input  logic                  i_q_full
);
    import vsd_pkg::*;

    logic signed [15:0] r_ref_x, r_ref_y, r_ref_hd;
    logic        [33:0] r_max_dsq, n_max_dsq;
    logic        [16:0] r_max_turn, n_max_turn;
    logic signed [15:0] r_filt_spd, n_filt_spd;
    logic signed [15:0] r_filt_rate, n_filt_rate;
    logic        [29:0] r_move_sq;

    logic               r_s1_vld;
    logic               r_s1_vel, r_s1_first, r_s1_last, r_s1_tr, r_s1_ps;
    logic        [33:0] r_s1_dsq;
    logic        [16:0] r_s1_turn;
    logic signed [28:0] r_s1_spd_p, r_s1_rate_p;

    logic               w_accept, w_is_vel, w_produce, w_adv;
    logic signed [16:0] w_dx, w_dy, w_dh;
    logic signed [33:0] w_dx2, w_dy2;
    logic        [16:0] w_turn;
    logic        [33:0] w_cur_dsq;
    logic        [16:0] w_cur_turn;
    logic signed [31:0] w_fs, w_fr;
    logic        [16:0] w_mag_spd, w_mag_rate;
    logic               w_traj_ev, w_vel_ev;

    assign w_accept = i_valid && o_ready;
    assign w_is_vel = (i_operation == OP_VELOCITY);

    always_comb begin
        w_dx   = i_first_point ? '0 : (17'(r_ref_x) - 17'(i_pos_x));
        w_dy   = i_first_point ? '0 : (17'(r_ref_y) - 17'(i_pos_y));
        w_dh   = i_first_point ? '0 : (17'(i_heading) - 17'(r_ref_hd));
        w_dx2  = 34'(w_dx) * 34'(w_dx);
        w_dy2  = 34'(w_dy) * 34'(w_dy);
        w_turn = w_dh[16] ? 17'(-w_dh) : 17'(w_dh);
    end

    always_comb begin
        w_cur_dsq  = r_s1_first ? '0 : r_max_dsq;
        w_cur_turn = r_s1_first ? '0 : r_max_turn;
        n_max_dsq  = (r_s1_dsq > w_cur_dsq) ? r_s1_dsq : w_cur_dsq;
        n_max_turn = (r_s1_turn > w_cur_turn) ? r_s1_turn : w_cur_turn;

        w_fs = (32'(r_filt_spd) * 32'(signed'({1'b0, KEEP_COEF})) + 32'(r_s1_spd_p)
                + 32'(signed'({1'b0, HALF_Q14}))) >>> 14;
        w_fr = (32'(r_filt_rate) * 32'(signed'({1'b0, KEEP_COEF})) + 32'(r_s1_rate_p)
                + 32'(signed'({1'b0, HALF_Q14}))) >>> 14;
        n_filt_spd  = w_fs[15:0];
        n_filt_rate = w_fr[15:0];

        w_mag_spd  = n_filt_spd[15] ? 17'(-17'(n_filt_spd)) : 17'(n_filt_spd);
        w_mag_rate = n_filt_rate[15] ? 17'(-17'(n_filt_rate)) : 17'(n_filt_rate);

        w_traj_ev = r_s1_ps && !r_s1_tr && (n_max_dsq < 34'(r_move_sq))
                    && (n_max_turn < 17'(i_cfg.min_turn));
        w_vel_ev  = (w_mag_spd < 17'(i_cfg.still_rate))
                    && (w_mag_rate < 17'(i_cfg.still_rate)) && !r_s1_tr;

        w_produce = r_s1_vel || r_s1_last;
        w_adv     = r_s1_vld && (!w_produce || !i_q_full);
    end

    assign o_ready             = !r_s1_vld || w_adv;
    assign o_push              = w_adv && w_produce;
    assign o_dec.from_velocity = r_s1_vel;
    assign o_dec.evidence      = r_s1_vel ? w_vel_ev : w_traj_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_ref_hd    <= '0;
            r_max_dsq   <= '0;
            r_max_turn  <= '0;
            r_filt_spd  <= '0;
            r_filt_rate <= '0;
        end else begin
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_accept && !w_is_vel && i_first_point) begin
                r_ref_x  <= i_pos_x;
                r_ref_y  <= i_pos_y;
                r_ref_hd <= i_heading;
            end
            if (w_adv && !r_s1_vel) begin
                r_max_dsq  <= n_max_dsq;
                r_max_turn <= n_max_turn;
            end
            if (w_adv && r_s1_vel) begin
                r_filt_spd  <= n_filt_spd;
                r_filt_rate <= n_filt_rate;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_move_sq <= 30'(i_cfg.min_move) * 30'(i_cfg.min_move);
        if (w_accept) begin
            r_s1_vel    <= w_is_vel;
            r_s1_first  <= i_first_point;
            r_s1_last   <= i_last_point;
            r_s1_tr     <= i_target_reached;
            r_s1_ps     <= i_planner_started;
            r_s1_dsq    <= 34'(w_dx2) + 34'(w_dy2);
            r_s1_turn   <= w_turn;
            r_s1_spd_p  <= 29'(i_speed) * 29'(signed'({1'b0, NEW_COEF}));
            r_s1_rate_p <= 29'(i_turn_rate) * 29'(signed'({1'b0, NEW_COEF}));
        end
    end

    a_ref_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_vel && i_first_point) |=>
            (r_ref_x == $past(i_pos_x) && r_ref_hd == $past(i_heading)))
        else $error("reference not loaded from first point");

endmodule

/* hw/rtl/vsd_queue.sv */
// ----------------------------------------------------------------------------
// vsd_queue
// Short decision queue between the classifying front and the scoring back.
// ----------------------------------------------------------------------------
module vsd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vsd_pkg::t_decision  i_dec,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output vsd_pkg::t_decision  o_dec
);
    import vsd_pkg::*;

    t_decision             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0]       r_count;
    logic                  w_push, w_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_dec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CW'(w_push) - Q_CW'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("decision pushed into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

/* hw/rtl/vsd_back.sv */
// ----------------------------------------------------------------------------
// vsd_back
// Applies queued decisions to the two evidence scores and registers results.
// ----------------------------------------------------------------------------
module vsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  vsd_pkg::t_decision  i_dec,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_stuck,
    output logic                o_from_velocity,
    output logic [14:0]         o_score
);
    import vsd_pkg::*;

    logic [SCORE_W-1:0] r_traj_score, r_vel_score;
    logic [SCORE_W-1:0] n_traj_score, n_vel_score;
    logic               r_o_vld, r_o_stuck, r_o_from_vel;
    logic [SCORE_W-1:0] r_o_score;

    logic [SCORE_W-1:0] w_cur, w_step, w_decay, w_new;
    logic [28:0]        w_prod;
    logic [29:0]        w_round;
    logic [SCORE_W:0]   w_sum;
    logic               w_stuck;

    assign o_pop = !i_empty && (!r_o_vld || i_ready);

    always_comb begin
        w_cur   = i_dec.from_velocity ? r_vel_score : r_traj_score;
        w_step  = i_dec.from_velocity ? VEL_STEP : TRAJ_STEP;
        w_prod  = 29'(w_cur) * 29'(KEEP_COEF);
        w_round = 30'(w_prod) + 30'(HALF_Q14);
        w_decay = w_round[28:14];
        w_sum   = 16'(w_cur) + 16'(w_step);
        if (!i_dec.evidence) begin
            w_new = w_decay;
        end else if (w_sum > 16'(SCORE_MAX)) begin
            w_new = SCORE_MAX;
        end else begin
            w_new = w_sum[SCORE_W-1:0];
        end
        w_stuck = (w_new > SCORE_ONE);

        n_traj_score = r_traj_score;
        n_vel_score  = r_vel_score;
        if (w_stuck) begin
            n_traj_score = '0;
            n_vel_score  = '0;
        end else if (i_dec.from_velocity) begin
            n_vel_score = w_new;
        end else begin
            n_traj_score = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_traj_score <= '0;
            r_vel_score  <= '0;
            r_o_vld      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_traj_score <= n_traj_score;
                r_vel_score  <= n_vel_score;
                r_o_vld      <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_stuck    <= w_stuck;
            r_o_from_vel <= i_dec.from_velocity;
            r_o_score    <= w_new;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_stuck         = r_o_stuck;
    assign o_from_velocity = r_o_from_vel;
    assign o_score         = r_o_score;

    a_stuck_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_stuck) |=> (r_traj_score == '0 && r_vel_score == '0))
        else $error("scores not cleared after stuck decision");

endmodule

/* hw/rtl/vehicle_stuck_detector.sv */
// ----------------------------------------------------------------------------
// vehicle_stuck_detector
// Flags a stuck ground vehicle from trajectory and velocity evidence scores.
//
// Input channel (i_valid/o_ready) takes one transaction per cycle while
// o_ready is high: either a planned trajectory point (operation 0) or a
// measured velocity sample (operation 1). Every velocity sample and every
// point marked last yields one result transaction on o_valid/i_ready; other
// points yield none. A result passes the front register stage, the decision
// queue and the scoring stage that loads the output register. Sustained
// throughput is one item per cycle while i_ready is high, set by the
// distance-max and filter recurrences in the front.
// A four-entry decision queue parts front and back: when the receiver stalls,
// the output register holds and the queue fills; o_ready drops only once the
// queue is full and a deciding item waits in the front stage.
// Configuration (i_cfg_valid/o_cfg_ready) is always ready; write only while
// the block is idle. Reset restores the default thresholds and clears the
// reference, maxima, filters and scores; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vehicle_stuck_detector (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [14:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_operation,
    input  logic                i_first_point,
    input  logic                i_last_point,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic signed [15:0]  i_heading,
    input  logic signed [15:0]  i_speed,
    input  logic signed [15:0]  i_turn_rate,
    input  logic                i_target_reached,
    input  logic                i_planner_started,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_stuck,
    output logic                o_from_velocity,
    output logic [14:0]         o_score
);
    import vsd_pkg::*;

    t_cfg       r_cfg;
    t_decision  w_push_dec, w_pop_dec;
    logic       w_push, w_full, w_empty, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_move   <= MIN_MOVE_RST;
            r_cfg.min_turn   <= MIN_TURN_RST;
            r_cfg.still_rate <= STILL_RATE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_MOVE:   r_cfg.min_move   <= i_cfg_data;
                CFG_MIN_TURN:   r_cfg.min_turn   <= i_cfg_data;
                CFG_STILL_RATE: r_cfg.still_rate <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vsd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_first_point     (i_first_point),
        .i_last_point      (i_last_point),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_heading         (i_heading),
        .i_speed           (i_speed),
        .i_turn_rate       (i_turn_rate),
        .i_target_reached  (i_target_reached),
        .i_planner_started (i_planner_started),
        .o_push            (w_push),
        .o_dec             (w_push_dec),
        .i_q_full          (w_full)
    );

    vsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_dec   (w_push_dec),
        .o_full  (w_full),
        .o_empty (w_empty),
        .i_pop   (w_pop),
        .o_dec   (w_pop_dec)
    );

    vsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_dec           (w_pop_dec),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_stuck         (o_stuck),
        .o_from_velocity (o_from_velocity),
        .o_score         (o_score)
    );

endmodule

/* test/tb_vehicle_stuck_detector.sv */
// ----------------------------------------------------------------------------
// tb_vehicle_stuck_detector
// Self-checking bench for the stuck detector. An in-bench score tracker
// mirrors the trajectory maxima, speed and turn-rate filters and both leaky
// scores, and queues the verdict each accepted transaction should produce.
// Directed plans and samples hit the threshold edges and marking corner
// cases; random plans, velocity bursts and noise then run under threshold
// sweeps and under sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_vehicle_stuck_detector;

    import vsd_pkg::*;

    typedef struct {
        t_op                op;
        logic               first_mark;
        logic               last_mark;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] hd;
        logic signed [15:0] spd;
        logic signed [15:0] rate;
        logic               reached;
        logic               started;
    } t_item;

    typedef struct {
        logic        stuck;
        logic        from_vel;
        logic [14:0] score;
    } t_verdict;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [14:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_operation;
    logic               i_first_point;
    logic               i_last_point;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic signed [15:0] i_heading;
    logic signed [15:0] i_speed;
    logic signed [15:0] i_turn_rate;
    logic               i_target_reached;
    logic               i_planner_started;
    logic               o_valid;
    logic               i_ready;
    logic               o_stuck;
    logic               o_from_velocity;
    logic [14:0]        o_score;

    vehicle_stuck_detector dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_first_point     (i_first_point),
        .i_last_point      (i_last_point),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_heading         (i_heading),
        .i_speed           (i_speed),
        .i_turn_rate       (i_turn_rate),
        .i_target_reached  (i_target_reached),
        .i_planner_started (i_planner_started),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_stuck           (o_stuck),
        .o_from_velocity   (o_from_velocity),
        .o_score           (o_score)
    );

    // score tracker state
    logic [14:0] thr_move;
    logic [14:0] thr_turn;
    logic [14:0] thr_still;
    int          ref_px;
    int          ref_py;
    int          ref_hd;
    longint      peak_dist_sq;
    int          peak_turn;
    int          traj_score;
    int          vel_score;
    int          speed_avg;
    int          rate_avg;

    t_verdict    expected_verdicts[$];
    t_verdict    want;
    int          mismatches;
    int          items_sent;
    int          results_seen;
    int          stuck_traj_seen;
    int          stuck_vel_seen;
    int          pred_stuck_traj;
    int          pred_stuck_vel;
    int          idle_pct;
    int          stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAIL vehicle_stuck_detector");
        $finish;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int score_raise(int s, int step);
        return (s + step > int'(SCORE_MAX)) ? int'(SCORE_MAX) : s + step;
    endfunction

    function automatic int score_decay(int s);
        return (s * int'(KEEP_COEF) + int'(HALF_Q14)) >>> 14;
    endfunction

    function automatic int smooth(int f, int x);
        longint acc;
        acc = longint'(f) * int'(KEEP_COEF) + longint'(x) * int'(NEW_COEF) + int'(HALF_Q14);
        return int'(acc >>> 14);
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) begin
            return 16'sd32767;
        end
        if (v < -32768) begin
            return -16'sd32768;
        end
        return 16'(v);
    endfunction

    task automatic update_scores(input t_item it);
        t_verdict v;
        longint   dx;
        longint   dy;
        longint   dsq;
        int       turn;
        int       s;
        bit       evid;
        if (it.op == OP_POINT) begin
            if (it.first_mark) begin
                ref_px       = it.px;
                ref_py       = it.py;
                ref_hd       = it.hd;
                peak_dist_sq = 0;
                peak_turn    = 0;
            end
            dx  = longint'(ref_px) - longint'(it.px);
            dy  = longint'(ref_py) - longint'(it.py);
            dsq = dx * dx + dy * dy;
            if (dsq > peak_dist_sq) begin
                peak_dist_sq = dsq;
            end
            turn = magnitude(int'(it.hd) - ref_hd);
            if (turn > peak_turn) begin
                peak_turn = turn;
            end
            if (!it.last_mark) begin
                return;
            end
            evid = it.started && !it.reached
                && (peak_dist_sq < longint'(thr_move) * longint'(thr_move))
                && (peak_turn < int'(thr_turn));
            traj_score = evid ? score_raise(traj_score, int'(TRAJ_STEP))
                              : score_decay(traj_score);
            s = traj_score;
            v.from_vel = 1'b0;
        end else begin
            speed_avg = smooth(speed_avg, int'(it.spd));
            rate_avg  = smooth(rate_avg, int'(it.rate));
            evid = magnitude(speed_avg) < int'(thr_still)
                && magnitude(rate_avg) < int'(thr_still) && !it.reached;
            vel_score = evid ? score_raise(vel_score, int'(VEL_STEP))
                             : score_decay(vel_score);
            s = vel_score;
            v.from_vel = 1'b1;
        end
        v.stuck = (s > int'(SCORE_ONE));
        v.score = s[14:0];
        if (v.stuck) begin
            traj_score = 0;
            vel_score  = 0;
            if (v.from_vel) begin
                pred_stuck_vel++;
            end else begin
                pred_stuck_traj++;
            end
        end
        expected_verdicts.insert(expected_verdicts.size(), v);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result with none expected: stuck=%0d from_velocity=%0d score=%0d",
                         $time, o_stuck, o_from_velocity, o_score);
                mismatches++;
            end else begin
                want = expected_verdicts[0];
                expected_verdicts.delete(0);
                if (o_stuck !== want.stuck || o_from_velocity !== want.from_vel
                        || o_score !== want.score) begin
                    $display("%0t: expected stuck=%0d from_velocity=%0d score=%0d, got %0d %0d %0d",
                             $time, want.stuck, want.from_vel, want.score,
                             o_stuck, o_from_velocity, o_score);
                    mismatches++;
                end
            end
            results_seen++;
            if (o_stuck === 1'b1) begin
                if (o_from_velocity) begin
                    stuck_vel_seen++;
                end else begin
                    stuck_traj_seen++;
                end
            end
        end
    end

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_operation       <= it.op;
        i_first_point     <= it.first_mark;
        i_last_point      <= it.last_mark;
        i_pos_x           <= it.px;
        i_pos_y           <= it.py;
        i_heading         <= it.hd;
        i_speed           <= it.spd;
        i_turn_rate       <= it.rate;
        i_target_reached  <= it.reached;
        i_planner_started <= it.started;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        update_scores(it);
        items_sent++;
    endtask

    task automatic settle_outputs();
        @(negedge i_clk);
        i_valid <= 1'b0;
        for (int n = 0; n < 20000 && expected_verdicts.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(input t_cfg_idx idx, input logic [14:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_MIN_MOVE:   thr_move  = val;
            CFG_MIN_TURN:   thr_turn  = val;
            CFG_STILL_RATE: thr_still = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [14:0] mv, input logic [14:0] tv,
                                  input logic [14:0] sv);
        settle_outputs();
        write_threshold(CFG_MIN_MOVE, mv);
        write_threshold(CFG_MIN_TURN, tv);
        write_threshold(CFG_STILL_RATE, sv);
    endtask

    function automatic t_item make_point(logic fm, logic lm, int x, int y, int h,
                                         logic reached, logic started);
        t_item p;
        p.op         = OP_POINT;
        p.first_mark = fm;
        p.last_mark  = lm;
        p.px         = clamp16(x);
        p.py         = clamp16(y);
        p.hd         = clamp16(h);
        p.spd        = 16'($urandom);
        p.rate       = 16'($urandom);
        p.reached    = reached;
        p.started    = started;
        return p;
    endfunction

    function automatic t_item make_sample(int spd, int rate, logic reached);
        t_item p;
        p.op         = OP_VELOCITY;
        p.first_mark = 1'($urandom);
        p.last_mark  = 1'($urandom);
        p.px         = 16'($urandom);
        p.py         = 16'($urandom);
        p.hd         = 16'($urandom);
        p.spd        = clamp16(spd);
        p.rate       = clamp16(rate);
        p.reached    = reached;
        p.started    = 1'($urandom);
        return p;
    endfunction

    function automatic t_item noise_item();
        t_item p;
        p.op         = t_op'($urandom_range(1));
        p.first_mark = 1'($urandom);
        p.last_mark  = 1'($urandom);
        p.px         = 16'($urandom);
        p.py         = 16'($urandom);
        p.hd         = 16'($urandom);
        p.spd        = 16'($urandom);
        p.rate       = 16'($urandom);
        p.reached    = 1'($urandom);
        p.started    = 1'($urandom);
        return p;
    endfunction

    // clean plans stay inside both thresholds and always carry both marks
    task automatic send_plan(input bit clean);
        t_item p;
        int    npts;
        int    bx;
        int    by;
        int    bh;
        int    mv;
        int    tv;
        bit    steady;
        bit    skip_first;
        bit    skip_last;
        logic  reached;
        logic  started;
        npts       = $urandom_range(1, 6);
        steady     = clean || ($urandom_range(9) < 7);
        skip_first = !clean && ($urandom_range(19) == 0);
        skip_last  = !clean && ($urandom_range(19) == 0);
        reached    = !clean && ($urandom_range(9) == 0);
        started    = clean || ($urandom_range(9) != 0);
        bx = int'($urandom_range(65535)) - 32768;
        by = int'($urandom_range(65535)) - 32768;
        bh = int'($urandom_range(65535)) - 32768;
        mv = int'(thr_move) / 2;
        tv = int'(thr_turn) / 2;
        for (int k = 0; k < npts; k++) begin
            if (!steady) begin
                p = make_point(1'b0, 1'b0, int'($urandom_range(65535)) - 32768,
                               int'($urandom_range(65535)) - 32768,
                               int'($urandom_range(65535)) - 32768, reached, started);
            end else if (k == 0) begin
                p = make_point(1'b0, 1'b0, bx, by, bh, reached, started);
            end else begin
                p = make_point(1'b0, 1'b0,
                               bx + int'($urandom_range(2 * mv)) - mv,
                               by + int'($urandom_range(2 * mv)) - mv,
                               bh + int'($urandom_range(2 * tv)) - tv, reached, started);
            end
            if (k == 0) begin
                bx = p.px;
                by = p.py;
                bh = p.hd;
            end
            p.first_mark = (k == 0) && !skip_first;
            p.last_mark  = (k == npts - 1) && !skip_last;
            send_item(p);
        end
    endtask

    task automatic send_velocity_burst(input int n, input bit clean);
        int   lim;
        bit   still;
        logic reached;
        lim     = (thr_still == 0) ? 0 : int'(thr_still) - 1;
        still   = clean || ($urandom_range(9) < 6);
        reached = !clean && ($urandom_range(9) == 0);
        repeat (n) begin
            if (still) begin
                send_item(make_sample(int'($urandom_range(2 * lim)) - lim,
                                      int'($urandom_range(2 * lim)) - lim, reached));
            end else begin
                send_item(make_sample(int'($urandom_range(65535)) - 32768,
                                      int'($urandom_range(65535)) - 32768, reached));
            end
        end
    endtask

    task automatic send_random_traffic();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_plan(1'b0);
        end else if (pick < 80) begin
            send_velocity_burst($urandom_range(1, 8), 1'b0);
        end else begin
            send_item(noise_item());
        end
    endtask

    task automatic test_directed_cases();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(make_sample(0, 0, 1'b0));
        send_item(make_sample(32767, -32768, 1'b0));
        send_item(make_sample(-32768, 32767, 1'b1));
        // last point before any first point uses the reset reference
        send_item(make_point(1'b0, 1'b1, 0, 0, 0, 1'b0, 1'b1));
        send_item(make_point(1'b0, 1'b1, 0, 0, 0, 1'b0, 1'b0));
        send_item(make_point(1'b0, 1'b1, 0, 0, 0, 1'b1, 1'b1));
        send_item(make_point(1'b1, 1'b0, -32768, -32768, -32768, 1'b0, 1'b1));
        send_item(make_point(1'b0, 1'b0, 32767, 32767, 32767, 1'b0, 1'b1));
        send_item(make_point(1'b0, 1'b1, 0, 0, 0, 1'b0, 1'b1));
        // points after the last keep feeding the maxima
        send_item(make_point(1'b0, 1'b0, 5, 5, 5, 1'b0, 1'b1));
        send_item(make_point(1'b0, 1'b1, 5, 5, 5, 1'b0, 1'b1));
        send_item(make_point(1'b1, 1'b1, 100, -100, 200, 1'b0, 1'b1));
        // distance exactly at the threshold, then just inside
        send_item(make_point(1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b1));
        send_item(make_point(1'b0, 1'b1, 102, 0, 0, 1'b0, 1'b1));
        send_item(make_point(1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b1));
        send_item(make_point(1'b0, 1'b1, 0, -101, 0, 1'b0, 1'b1));
        // heading change exactly at the threshold, then just inside
        send_item(make_point(1'b1, 1'b0, 0, 0, 2048, 1'b0, 1'b1));
        send_item(make_point(1'b0, 1'b1, 0, 0, 1024, 1'b0, 1'b1));
        send_item(make_point(1'b1, 1'b0, 0, 0, -500, 1'b0, 1'b1));
        send_item(make_point(1'b0, 1'b1, 0, 0, 523, 1'b0, 1'b1));
        send_item(make_sample(327, -327, 1'b0));
        send_item(make_sample(-328, 328, 1'b0));
    endtask

    task automatic test_trajectory_stuck();
        int start;
        start = pred_stuck_traj;
        for (int n = 0; n < 14 && pred_stuck_traj == start; n++) begin
            send_plan(1'b1);
        end
    endtask

    task automatic test_velocity_stuck();
        int start;
        start = pred_stuck_vel;
        for (int n = 0; n < 80 && pred_stuck_vel == start; n++) begin
            send_velocity_burst(1, 1'b1);
        end
    endtask

    task automatic test_threshold_sweep();
        logic [14:0] sets [5][3];
        sets = '{'{15'd0, 15'd0, 15'd0},
                 '{15'd32767, 15'd32767, 15'd32767},
                 '{15'd1, 15'd32767, 15'd0},
                 '{15'd32767, 15'd0, 15'd32767},
                 '{MIN_MOVE_RST, MIN_TURN_RST, STILL_RATE_RST}};
        foreach (sets[i]) begin
            set_thresholds(sets[i][0], sets[i][1], sets[i][2]);
            repeat (12) send_random_traffic();
            test_trajectory_stuck();
            test_velocity_stuck();
        end
    endtask

    task automatic test_random_phases();
        int idle_set [4];
        int stall_set [4];
        int goal;
        idle_set  = '{0, 52, 0, 22};
        stall_set = '{0, 0, 52, 22};
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 0) begin
                set_thresholds(MIN_MOVE_RST, MIN_TURN_RST, STILL_RATE_RST);
            end else begin
                set_thresholds(15'($urandom_range(20, 400)), 15'($urandom_range(200, 4000)),
                               15'($urandom_range(100, 1000)));
            end
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            goal = items_sent + 350;
            while (items_sent < goal) begin
                send_random_traffic();
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_MIN_MOVE;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_operation       = OP_POINT;
        i_first_point     = 1'b0;
        i_last_point      = 1'b0;
        i_pos_x           = '0;
        i_pos_y           = '0;
        i_heading         = '0;
        i_speed           = '0;
        i_turn_rate       = '0;
        i_target_reached  = 1'b0;
        i_planner_started = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        mismatches        = 0;
        items_sent        = 0;
        results_seen      = 0;
        stuck_traj_seen   = 0;
        stuck_vel_seen    = 0;
        pred_stuck_traj   = 0;
        pred_stuck_vel    = 0;
        thr_move          = MIN_MOVE_RST;
        thr_turn          = MIN_TURN_RST;
        thr_still         = STILL_RATE_RST;
        ref_px            = 0;
        ref_py            = 0;
        ref_hd            = 0;
        peak_dist_sq      = 0;
        peak_turn         = 0;
        traj_score        = 0;
        vel_score         = 0;
        speed_avg         = 0;
        rate_avg          = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_trajectory_stuck();
        test_velocity_stuck();
        test_threshold_sweep();
        test_random_phases();
        settle_outputs();

        mismatches += expected_verdicts.size();
        $display("Run covered %0d input transactions and %0d result transactions",
                 items_sent, results_seen);
        $display("Stuck raised %0d times by trajectory score, %0d by velocity score",
                 stuck_traj_seen, stuck_vel_seen);
        if (mismatches == 0) begin
            $display("PASS vehicle_stuck_detector");
        end else begin
            $display("FAIL vehicle_stuck_detector");
        end
        $finish;
    end

endmodule
